### hw/rtl/ric_pkg.sv
// ----------------------------------------------------------------------------
// Route insertion check package
// Shared types, register indexes, codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ric_pkg;

  localparam int RIC_MAX_REQUESTS = 256;
  localparam int RIC_QUEUE_DEPTH  = 2;
  localparam int RIC_CFG_IDX_W    = 8;
  localparam int RIC_CFG_DATA_W   = 32;

  localparam logic [RIC_CFG_IDX_W-1:0] REG_CAPACITY     = RIC_CFG_IDX_W'(0);
  localparam logic [RIC_CFG_IDX_W-1:0] REG_MAX_RIDE     = RIC_CFG_IDX_W'(1);
  localparam logic [RIC_CFG_IDX_W-1:0] REG_MAX_DURATION = RIC_CFG_IDX_W'(2);
  localparam logic [RIC_CFG_IDX_W-1:0] REG_BASE_COST    = RIC_CFG_IDX_W'(3);

  localparam logic [7:0]  CAPACITY_RESET     = 8'hFF;
  localparam logic [23:0] MAX_RIDE_RESET     = 24'hFF_FFFF;
  localparam logic [23:0] MAX_DURATION_RESET = 24'hFF_FFFF;
  localparam logic [30:0] BASE_COST_RESET    = 31'd0;

  localparam logic [1:0] KIND_OTHER    = 2'd0;
  localparam logic [1:0] KIND_PICKUP   = 2'd1;
  localparam logic [1:0] KIND_DELIVERY = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_LATE     = 3'd1,
    CAUSE_OVERLOAD = 3'd2,
    CAUSE_RIDE     = 3'd3,
    CAUSE_DURATION = 3'd4
  } ric_cause_e;

  typedef struct packed {
    logic              route_start;
    logic [1:0]        node_kind;
    logic [7:0]        request_index;
    logic [15:0]       arc_time;
    logic [15:0]       arc_cost;
    logic [23:0]       window_open;
    logic [23:0]       window_close;
    logic signed [7:0] demand;
    logic [15:0]       service_time;
    logic              last;
  } ric_in_t;

  typedef struct packed {
    logic               feasible;
    logic signed [31:0] cost_delta;
    logic [2:0]         fail_cause;
  } ric_out_t;

  typedef struct packed {
    logic [RIC_CFG_IDX_W-1:0]  index;
    logic [RIC_CFG_DATA_W-1:0] value;
  } ric_cfg_t;

  typedef struct packed {
    logic [7:0]  capacity;
    logic [23:0] max_ride;
    logic [23:0] max_duration;
    logic [30:0] base_cost;
  } ric_limits_t;

  typedef struct packed {
    logic               start;
    logic               last;
    logic               pickup;
    logic               delivery;
    logic               req_ok;
    logic [7:0]         req;
    logic [15:0]        arc_time;
    logic [15:0]        arc_cost;
    logic [23:0]        window_open;
    logic [23:0]        window_close;
    logic signed [11:0] demand;
    logic [15:0]        service_time;
  } ric_item_t;

  typedef struct packed {
    logic [23:0] arrival;
    logic [15:0] service;
  } ric_pick_t;

endpackage

`default_nettype wire

### hw/rtl/ric_stream_if.sv
// ----------------------------------------------------------------------------
// Route insertion check stream interface
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ric_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ric_front.sv
// ----------------------------------------------------------------------------
// Route insertion check front end
// Accepts visit words and classifies them for the execution queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ric_front #(
  parameter int MAX_REQUESTS = ric_pkg::RIC_MAX_REQUESTS
) (
  ric_stream_if.sink          in_i,
  input  logic                full_i,
  output logic                push_o,
  output ric_pkg::ric_item_t  item_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.start        = in_i.data.route_start;
    item_o.last         = in_i.data.last;
    item_o.pickup       = (in_i.data.node_kind == ric_pkg::KIND_PICKUP);
    item_o.delivery     = (in_i.data.node_kind == ric_pkg::KIND_DELIVERY);
    item_o.req_ok       = ({24'd0, in_i.data.request_index} < 32'(MAX_REQUESTS));
    item_o.req          = in_i.data.request_index;
    item_o.arc_time     = in_i.data.arc_time;
    item_o.arc_cost     = in_i.data.arc_cost;
    item_o.window_open  = in_i.data.window_open;
    item_o.window_close = in_i.data.window_close;
    item_o.demand       = {{4{in_i.data.demand[7]}}, in_i.data.demand};
    item_o.service_time = in_i.data.service_time;
  end

endmodule

`default_nettype wire

### hw/rtl/ric_queue.sv
// ----------------------------------------------------------------------------
// Route insertion check queue
// Short FIFO that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ric_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ric_pkg::ric_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ric_pkg::ric_item_t item_o
);

  localparam int Depth = ric_pkg::RIC_QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ric_pkg::ric_item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ric_back.sv
// ----------------------------------------------------------------------------
// Route insertion check back end
// Walks the route state, checks limits and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ric_back #(
  parameter int MAX_REQUESTS = ric_pkg::RIC_MAX_REQUESTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ric_pkg::ric_limits_t limits_i,
  input  logic                 valid_i,
  input  ric_pkg::ric_item_t   item_i,
  output logic                 pop_o,
  ric_stream_if.source         out_o
);

  localparam int AddrW = $clog2(MAX_REQUESTS);

  // Route state, owned by the first stage.
  logic [23:0]             cur_q, start_q;
  logic signed [11:0]      load_q;
  logic [31:0]             cost_q;
  logic [15:0]             svc_q;
  logic [MAX_REQUESTS-1:0] seen_q;
  ric_pkg::ric_pick_t      pick_mem [MAX_REQUESTS];
  ric_pkg::ric_pick_t      rd_q;

  // Second stage.
  logic                b_valid_q, b_valid_d;
  logic                b_start_q, b_last_q, b_ride_q, b_dur_q;
  ric_pkg::ric_cause_e b_cause_q, fail_q, cause_b;
  logic [23:0]         b_cur_q;
  logic [31:0]         b_cost_q;

  logic     out_valid_q;
  ric_pkg::ric_out_t out_q;

  logic              a_adv, b_adv, out_free;
  logic [AddrW+7:0]  req_ext;
  logic [AddrW-1:0]  addr;
  logic [25:0]       arrival, arr_clamp;
  logic [23:0]       arr_time;
  logic              late, over, pass, seen_hit, pick_wr, ride_chk, dur_fail;
  logic signed [12:0] load_sum;
  logic signed [11:0] load_new;
  logic [32:0]       cost_sum;
  logic [31:0]       cost_new;
  logic [24:0]       dur_diff, pdone, ride_diff;
  logic              ride_fail;
  logic signed [33:0] delta;
  logic [31:0]       delta_sat;
  ric_pkg::ric_cause_e cause_a;

  assign out_free  = !out_valid_q || out_o.ready;
  assign b_adv     = b_valid_q && (!b_last_q || out_free);
  assign a_adv     = valid_i && (!b_valid_q || b_adv);
  assign pop_o     = a_adv;
  assign b_valid_d = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_q);

  assign req_ext = {{AddrW{1'b0}}, item_i.req};
  assign addr    = req_ext[AddrW-1:0];

  always_comb begin
    arrival   = {2'b00, cur_q} + {10'd0, svc_q} + {10'd0, item_i.arc_time};
    arr_clamp = (arrival < {2'b00, item_i.window_open}) ?
                {2'b00, item_i.window_open} : arrival;
    late      = (arr_clamp > {2'b00, item_i.window_close});
    arr_time  = arr_clamp[23:0];

    load_sum = {load_q[11], load_q} + {item_i.demand[11], item_i.demand};
    if (load_sum[12] != load_sum[11]) begin
      load_new = load_sum[12] ? 12'sh800 : 12'sh7FF;
    end else begin
      load_new = load_sum[11:0];
    end
    over = (load_new > $signed({4'd0, limits_i.capacity}));

    cost_sum = {1'b0, cost_q} + {17'd0, item_i.arc_cost};
    cost_new = cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];

    dur_diff = {1'b0, arr_time} - {1'b0, start_q};
    dur_fail = item_i.last && ($signed(dur_diff) > $signed({1'b0, limits_i.max_duration}));

    pass     = !late && !over;
    seen_hit = item_i.req_ok && seen_q[addr];
    pick_wr  = !item_i.start && pass && item_i.pickup && item_i.req_ok;
    ride_chk = !item_i.start && pass && item_i.delivery && seen_hit;

    if (late) begin
      cause_a = ric_pkg::CAUSE_LATE;
    end else if (over) begin
      cause_a = ric_pkg::CAUSE_OVERLOAD;
    end else begin
      cause_a = ric_pkg::CAUSE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      start_q <= '0;
      load_q  <= '0;
      cost_q  <= '0;
      svc_q   <= '0;
      seen_q  <= '0;
    end else if (a_adv) begin
      if (item_i.start) begin
        cur_q   <= item_i.window_open;
        start_q <= item_i.window_open;
        load_q  <= '0;
        cost_q  <= '0;
        svc_q   <= item_i.service_time;
        seen_q  <= '0;
      end else begin
        cost_q <= cost_new;
        if (!late) begin
          cur_q  <= arr_time;
          load_q <= load_new;
        end
        if (pass) begin
          svc_q <= item_i.service_time;
        end
        if (pick_wr) begin
          seen_q[addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && pick_wr) begin
      pick_mem[addr] <= '{arrival: arr_time, service: item_i.service_time};
    end
    if (a_adv && item_i.req_ok) begin
      rd_q <= pick_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_start_q <= item_i.start;
      b_last_q  <= item_i.last;
      b_ride_q  <= ride_chk;
      b_dur_q   <= dur_fail;
      b_cause_q <= cause_a;
      b_cur_q   <= arr_time;
      b_cost_q  <= item_i.start ? 32'd0 : cost_new;
    end
  end

  always_comb begin
    pdone     = {1'b0, rd_q.arrival} + {9'd0, rd_q.service};
    ride_diff = {1'b0, b_cur_q} - pdone;
    ride_fail = b_ride_q && ({1'b0, b_cur_q} > pdone) &&
                (ride_diff > {1'b0, limits_i.max_ride});

    if (b_start_q) begin
      cause_b = ric_pkg::CAUSE_NONE;
    end else if (fail_q != ric_pkg::CAUSE_NONE) begin
      cause_b = fail_q;
    end else if (b_cause_q != ric_pkg::CAUSE_NONE) begin
      cause_b = b_cause_q;
    end else if (ride_fail) begin
      cause_b = ric_pkg::CAUSE_RIDE;
    end else if (b_dur_q) begin
      cause_b = ric_pkg::CAUSE_DURATION;
    end else begin
      cause_b = ric_pkg::CAUSE_NONE;
    end

    delta = $signed({2'b00, b_cost_q}) - $signed({3'b000, limits_i.base_cost});
    if (!delta[33] && (delta[32] || delta[31])) begin
      delta_sat = 32'h7FFF_FFFF;
    end else begin
      delta_sat = delta[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fail_q      <= ric_pkg::CAUSE_NONE;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (b_adv) begin
        fail_q <= cause_b;
      end
      if (b_adv && b_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_last_q) begin
      out_q.feasible   <= (cause_b == ric_pkg::CAUSE_NONE);
      out_q.cost_delta <= (cause_b == ric_pkg::CAUSE_NONE) ? $signed(delta_sat) : 32'sd0;
      out_q.fail_cause <= cause_b;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

### hw/rtl/route_insertion_feasibility_check.sv
// ----------------------------------------------------------------------------
// Route insertion feasibility check
// Walks one spliced vehicle route, one visit word per cycle unless out_o
// stalls, and reports feasibility and cost change at the end depot.
// ----------------------------------------------------------------------------
// Channels: in_i takes one visit word per accepted handshake; out_o returns
// one result word for every visit word marked last; cfg_i writes the four
// limit registers by index and is always ready. Writes to other indexes are
// dropped. Configuration must be written by the user only while no route
// word is in flight; the block does not enforce this. Throughput is one visit
// word per cycle while the result channel does not stall, set by the state
// update of the execution stage. A result word is registered after its last
// visit word passes from the head of the two-entry queue into the execution
// stage, which updates the route state, and then into the second stage, where
// the ride check runs on the stored pickup.
// When out_o stalls, the result register holds its word, the second stage
// holds the next last word, and the queue fills; in_i drops ready once the
// queue is full. Words that produce no result keep flowing past a stalled
// result until the second stage holds a last word. Reset clears the route
// state, the pickup flags, the pipeline and the result valid flag, and loads
// the limit registers with their defaults; the block is ready as soon as
// reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module route_insertion_feasibility_check #(
  parameter int MAX_REQUESTS = ric_pkg::RIC_MAX_REQUESTS
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ric_stream_if.sink   cfg_i,
  ric_stream_if.sink   in_i,
  ric_stream_if.source out_o
);

  ric_pkg::ric_limits_t limits_q;
  ric_pkg::ric_item_t   front_item, queue_item;
  logic                 push, full, pop, queue_valid;
  logic                 cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.capacity     <= ric_pkg::CAPACITY_RESET;
      limits_q.max_ride     <= ric_pkg::MAX_RIDE_RESET;
      limits_q.max_duration <= ric_pkg::MAX_DURATION_RESET;
      limits_q.base_cost    <= ric_pkg::BASE_COST_RESET;
    end else if (cfg_we) begin
      case (cfg_i.data.index)
        ric_pkg::REG_CAPACITY:     limits_q.capacity     <= cfg_i.data.value[7:0];
        ric_pkg::REG_MAX_RIDE:     limits_q.max_ride     <= cfg_i.data.value[23:0];
        ric_pkg::REG_MAX_DURATION: limits_q.max_duration <= cfg_i.data.value[23:0];
        ric_pkg::REG_BASE_COST:    limits_q.base_cost    <= cfg_i.data.value[30:0];
        default: begin
        end
      endcase
    end
  end

  ric_front #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  ric_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  ric_back #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .limits_i (limits_q),
    .valid_i  (queue_valid),
    .item_i   (queue_item),
    .pop_o    (pop),
    .out_o    (out_o)
  );

`ifndef NO_ASSERTIONS
  a_feasible_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.data.feasible == (out_o.data.fail_cause == ric_pkg::CAUSE_NONE)))
    else $error("feasible flag disagrees with failure cause");

  a_failed_zero_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.feasible) |-> (out_o.data.cost_delta == 32'sd0))
    else $error("infeasible result carries a nonzero cost change");

  a_cfg_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.data.index == ric_pkg::REG_CAPACITY) |=>
      (limits_q.capacity == $past(cfg_i.data.value[7:0])))
    else $error("capacity register write lost");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> queue_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_route_insertion_feasibility_check.sv
// ----------------------------------------------------------------------------
// Route insertion feasibility check testbench
// Sends directed and random visit words through the block under several limit
// settings, with random idling on the visit and verdict channels. A predictor
// computes the verdict word for every accepted last visit, and each verdict
// word is compared with it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_route_insertion_feasibility_check;

  localparam int CYCLE_LIMIT = 400_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ric_stream_if #(.T(ric_pkg::ric_cfg_t)) cfg_if ();
  ric_stream_if #(.T(ric_pkg::ric_in_t))  visit_if ();
  ric_stream_if #(.T(ric_pkg::ric_out_t)) verdict_if ();

  route_insertion_feasibility_check i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (visit_if),
    .out_o  (verdict_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ric_pkg::ric_in_t  pending_visits[$];
  ric_pkg::ric_out_t verdicts_due[$];
  int                visits_queued = 0;
  int                visits_taken  = 0;
  int                errors        = 0;
  int                cycles        = 0;
  bit                steady        = 1'b0;

  logic [7:0]          lim_capacity = ric_pkg::CAPACITY_RESET;
  logic [23:0]         lim_ride     = ric_pkg::MAX_RIDE_RESET;
  logic [23:0]         lim_duration = ric_pkg::MAX_DURATION_RESET;
  logic [30:0]         lim_base     = ric_pkg::BASE_COST_RESET;
  logic [24:0]         cur_time     = '0;
  logic [23:0]         route_t0     = '0;
  logic signed [11:0]  load         = '0;
  logic [31:0]         cost_acc     = '0;
  logic [15:0]         prev_svc     = '0;
  ric_pkg::ric_cause_e cause        = ric_pkg::CAUSE_NONE;
  bit                  pick_seen [ric_pkg::RIC_MAX_REQUESTS];
  logic [24:0]         pick_done [ric_pkg::RIC_MAX_REQUESTS];

  task automatic advance_route(input ric_pkg::ric_in_t w);
    logic [32:0]       csum;
    longint            arrive;
    longint            ride;
    longint            delta;
    int                ld;
    ric_pkg::ric_out_t v;
    if (w.route_start) begin
      cur_time = {1'b0, w.window_open};
      route_t0 = w.window_open;
      load     = '0;
      cost_acc = '0;
      cause    = ric_pkg::CAUSE_NONE;
      prev_svc = w.service_time;
      foreach (pick_seen[k]) pick_seen[k] = 1'b0;
    end else if (cause == ric_pkg::CAUSE_NONE) begin
      csum = cost_acc + w.arc_cost;
      cost_acc = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
      arrive = longint'(cur_time) + longint'(prev_svc) + longint'(w.arc_time);
      if (arrive < longint'(w.window_open)) arrive = longint'(w.window_open);
      if (arrive > longint'(w.window_close)) begin
        cause = ric_pkg::CAUSE_LATE;
      end else begin
        cur_time = arrive[24:0];
        ld = int'(load) + int'(w.demand);
        if (ld > 2047) ld = 2047;
        if (ld < -2048) ld = -2048;
        load = 12'(ld);
        if (ld > int'(lim_capacity)) begin
          cause = ric_pkg::CAUSE_OVERLOAD;
        end else begin
          prev_svc = w.service_time;
          if (w.node_kind == ric_pkg::KIND_PICKUP) begin
            pick_seen[w.request_index] = 1'b1;
            pick_done[w.request_index] = cur_time + w.service_time;
          end else if (w.node_kind == ric_pkg::KIND_DELIVERY &&
                       pick_seen[w.request_index]) begin
            ride = longint'(cur_time) - longint'(pick_done[w.request_index]);
            if (ride > longint'(lim_ride)) cause = ric_pkg::CAUSE_RIDE;
          end
        end
      end
      if (w.last && cause == ric_pkg::CAUSE_NONE &&
          longint'(cur_time) - longint'(route_t0) > longint'(lim_duration)) begin
        cause = ric_pkg::CAUSE_DURATION;
      end
    end
    if (w.last) begin
      delta = longint'(cost_acc) - longint'(lim_base);
      if (delta > 64'sd2147483647) delta = 64'sd2147483647;
      if (cause != ric_pkg::CAUSE_NONE) delta = 0;
      v.feasible   = (cause == ric_pkg::CAUSE_NONE);
      v.cost_delta = delta[31:0];
      v.fail_cause = cause;
      verdicts_due = {verdicts_due, v};
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (visit_if.valid && visit_if.ready) begin
        visits_taken++;
        advance_route(visit_if.data);
      end
      if (!visit_if.valid || visit_if.ready) begin
        if (pending_visits.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
          visit_if.data  <= pending_visits.pop_front();
          visit_if.valid <= 1'b1;
        end else begin
          visit_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : verdict_monitor
    ric_pkg::ric_out_t want;
    if (rst_ni) begin
      if (verdict_if.valid && verdict_if.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict word with none expected: %p", verdict_if.data);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (verdict_if.data.feasible !== want.feasible) begin
            $error("feasible: expected %0b, actual %0b", want.feasible,
                   verdict_if.data.feasible);
            errors++;
          end
          if (verdict_if.data.cost_delta !== want.cost_delta) begin
            $error("cost_delta: expected %0d, actual %0d", want.cost_delta,
                   verdict_if.data.cost_delta);
            errors++;
          end
          if (verdict_if.data.fail_cause !== want.fail_cause) begin
            $error("fail_cause: expected %0d, actual %0d", want.fail_cause,
                   verdict_if.data.fail_cause);
            errors++;
          end
        end
      end
      verdict_if.ready <= steady || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic ric_pkg::ric_in_t visit_word(input bit st, input logic [1:0] kind,
                                                  input int req, input int at, input int ac,
                                                  input int wo, input int wc, input int dem,
                                                  input int svc, input bit fin);
    ric_pkg::ric_in_t w;
    w.route_start   = st;
    w.node_kind     = kind;
    w.request_index = 8'(req);
    w.arc_time      = 16'(at);
    w.arc_cost      = 16'(ac);
    w.window_open   = 24'(wo);
    w.window_close  = 24'(wc);
    w.demand        = 8'(dem);
    w.service_time  = 16'(svc);
    w.last          = fin;
    return w;
  endfunction

  task automatic queue_visit(input ric_pkg::ric_in_t w);
    pending_visits = {pending_visits, w};
    visits_queued++;
  endtask

  task automatic set_limit(input logic [ric_pkg::RIC_CFG_IDX_W-1:0] idx,
                           input logic [31:0] wdata);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: wdata};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      ric_pkg::REG_CAPACITY:     lim_capacity = wdata[7:0];
      ric_pkg::REG_MAX_RIDE:     lim_ride     = wdata[23:0];
      ric_pkg::REG_MAX_DURATION: lim_duration = wdata[23:0];
      ric_pkg::REG_BASE_COST:    lim_base     = wdata[30:0];
      default: ;
    endcase
  endtask

  // Waits until every word is taken and every verdict has come, then lets the
  // pipeline empty of words that produce no verdict.
  task automatic drain();
    while (visits_taken != visits_queued || verdicts_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic plan_route(input bit broken);
    int         pairs, made, steps, j, slot, at, svc, dem, wo, wc, mid, req;
    longint     t_est, lo;
    int         open_req[$];
    int         open_dem[$];
    bit         tight, skip_start;
    logic [1:0] kind;
    pairs      = $urandom_range(0, 4);
    steps      = 2 * pairs + $urandom_range(0, 2);
    tight      = ($urandom_range(0, 99) < 20);
    skip_start = broken && $urandom_range(0, 1);
    mid        = (broken && !skip_start) ? $urandom_range(0, steps) : -1;
    t_est      = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 200000)
                                               : $urandom_range(0, 24'hFF_FFFF);
    svc        = $urandom_range(0, 600);
    made       = 0;
    if (!skip_start) begin
      queue_visit(visit_word(1'b1, 2'($urandom_range(0, 3)), $urandom_range(0, 255),
                             $urandom_range(0, 65535), $urandom_range(0, 65535), int'(t_est),
                             $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 255), svc,
                             1'b0));
    end
    for (j = 0; j <= steps; j++) begin
      at = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
      t_est += svc + at;
      svc = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 600) : $urandom_range(0, 65535);
      dem = 0;
      req = $urandom_range(0, 255);
      if (j == steps) begin
        kind = ric_pkg::KIND_OTHER;
      end else if (made < pairs && (open_req.size() == 0 || $urandom_range(0, 1))) begin
        kind = ric_pkg::KIND_PICKUP;
        dem  = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 20) : $urandom_range(1, 127);
        open_req = {open_req, req};
        open_dem = {open_dem, dem};
        made++;
      end else if (open_req.size() != 0) begin
        slot = $urandom_range(0, open_req.size() - 1);
        kind = ric_pkg::KIND_DELIVERY;
        req  = open_req[slot];
        dem  = -open_dem[slot];
        open_req.delete(slot);
        open_dem.delete(slot);
      end else begin
        kind = $urandom_range(0, 1) ? ric_pkg::KIND_OTHER : ric_pkg::KIND_UNUSED;
      end
      if (tight) begin
        lo = t_est + $urandom_range(0, 400);
        wo = (lo > 24'hFF_FFFF) ? 24'hFF_FFFF : int'(lo);
        lo = t_est + $urandom_range(0, 3000) - 150;
        if (lo < 0) lo = 0;
        wc = (lo > 24'hFF_FFFF) ? 24'hFF_FFFF : int'(lo);
      end else begin
        lo = t_est + 100;
        if (lo > 24'hFF_FFFF) lo = 24'hFF_FFFF;
        wo = $urandom_range(0, int'(lo));
        wc = 24'hFF_FFFF;
      end
      if (wo > t_est) t_est = wo;
      queue_visit(visit_word(1'b0, kind, req, at, $urandom_range(0, 65535), wo, wc, dem, svc,
                             j == steps || j == mid));
    end
  endtask

  task automatic run_random(input int n);
    int               target, pick, k;
    ric_pkg::ric_in_t w;
    target = visits_queued + n;
    @(negedge clk_i);
    while (visits_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 83) begin
        plan_route(1'b0);
      end else if (pick < 91) begin
        plan_route(1'b1);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4)) begin
          w.route_start   = ($urandom_range(0, 99) < 15);
          w.node_kind     = 2'($urandom_range(0, 3));
          w.request_index = 8'($urandom);
          w.arc_time      = 16'($urandom);
          w.arc_cost      = 16'($urandom);
          w.window_open   = 24'($urandom);
          w.window_close  = 24'($urandom);
          w.demand        = 8'($urandom);
          w.service_time  = 16'($urandom);
          w.last          = ($urandom_range(0, 99) < 20);
          queue_visit(w);
        end
      end else begin
        // A long run of unloading stops drives the load into its lower limit.
        queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, $urandom_range(0, 1000),
                               24'hFF_FFFF, 0, $urandom_range(0, 50), 1'b0));
        for (k = 0; k < 18; k++) begin
          queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, $urandom_range(0, 10),
                                 $urandom_range(0, 65535), 0, 24'hFF_FFFF, -128,
                                 $urandom_range(0, 10), 1'b0));
        end
        queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 1, 1, 0, 24'hFF_FFFF, 127, 0,
                               1'b0));
        queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 1, 1, 0, 24'hFF_FFFF, 0, 0,
                               1'b1));
      end
    end
    drain();
  endtask

  initial begin
    int p;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    visit_if.valid   = 1'b0;
    visit_if.data    = '0;
    verdict_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 7, 10, 5, 0, 24'hFF_FFFF, 3, 4, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_DELIVERY, 7, 20, 6, 0, 24'hFF_FFFF, -3, 0,
                           1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 65535, 65535, 100, 0, 127, 65535,
                           1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_UNUSED, 255, 65535, 65535, 0, 24'hFF_FFFF, 127,
                           65535, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 255, 0, 0, 24'hFF_FF00, 24'hFF_FFFF,
                           -128, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_DELIVERY, 0, 1, 1, 0, 24'hFF_FFFF, 0, 1, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_DELIVERY, 255, 5, 1, 0, 24'hFF_FFFF, 0, 0,
                           1'b1));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 0, 3, 0, 24'hFF_FFFF, 0, 0, 1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 50, 60, 0, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 0, 2, 200, 100, 0, 0, 1'b1));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 1, 1, 1, 0, 24'hFF_FFFF, 127, 1, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 2, 1, 1, 0, 24'hFF_FFFF, 127, 1, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 3, 1, 1, 0, 24'hFF_FFFF, 1, 1, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 4, 1, 1, 0, 24'hFF_FFFF, 1, 1, 1'b1));
    drain();

    set_limit(ric_pkg::REG_CAPACITY, 32'd0);
    set_limit(ric_pkg::REG_MAX_RIDE, 32'd0);
    set_limit(ric_pkg::REG_MAX_DURATION, 32'd0);
    set_limit(ric_pkg::REG_BASE_COST, 32'h7FFF_FFFF);
    @(negedge clk_i);
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 10, 24'hFF_FFFF, 0, 5, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 3, 1, 1, 0, 24'hFF_FFFF, 0, 10, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_DELIVERY, 3, 1, 1, 0, 24'hFF_FFFF, 0, 0, 1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 5, 1, 0, 24'hFF_FFFF, 0, 0, 1'b1));
    queue_visit(visit_word(1'b1, ric_pkg::KIND_OTHER, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_PICKUP, 9, 1, 1, 0, 24'hFF_FFFF, 1, 0, 1'b0));
    queue_visit(visit_word(1'b0, ric_pkg::KIND_OTHER, 0, 1, 1, 0, 24'hFF_FFFF, 0, 0, 1'b1));
    run_random(200);

    set_limit(ric_pkg::REG_CAPACITY, 32'd255);
    set_limit(ric_pkg::REG_MAX_RIDE, 32'hFF_FFFF);
    set_limit(ric_pkg::REG_MAX_DURATION, 32'hFF_FFFF);
    set_limit(ric_pkg::REG_BASE_COST, 32'd0);
    steady = 1'b1;
    run_random(300);
    steady = 1'b0;

    for (p = 0; p < 4; p++) begin
      if (p == 3) begin
        set_limit(ric_pkg::REG_CAPACITY, $urandom_range(0, 255));
        set_limit(ric_pkg::REG_MAX_RIDE, $urandom & 32'hFF_FFFF);
        set_limit(ric_pkg::REG_MAX_DURATION, $urandom & 32'hFF_FFFF);
        set_limit(ric_pkg::REG_BASE_COST, $urandom & 32'h7FFF_FFFF);
      end else begin
        set_limit(ric_pkg::REG_CAPACITY, $urandom_range(4, 40));
        set_limit(ric_pkg::REG_MAX_RIDE, $urandom_range(0, 20000));
        set_limit(ric_pkg::REG_MAX_DURATION, $urandom_range(3000, 60000));
        set_limit(ric_pkg::REG_BASE_COST, $urandom_range(0, 30000));
      end
      run_random(300);
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
